// ===== hdl/mwsf_pkg.sv =====
// shared types, constants and helpers of the mecanum wheel setpoint filter
`default_nettype none

package mwsf_pkg;

    localparam int WHEEL_COUNT = 4;
    localparam int WHEEL_W     = $clog2(WHEEL_COUNT);
    localparam int IN_W        = 16;
    localparam int TGT_W       = 24;
    localparam int COEF_W      = 17;
    localparam int ALPHA_W     = 17;
    localparam int RADIUS_W    = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 17;
    localparam int MUL_A_W     = 26;
    localparam int MUL_B_W     = 18;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W       = 52;
    localparam int VL_W        = 17;
    localparam int NEW_SHIFT   = 24;
    localparam int ALPHA_SHIFT = 16;
    localparam int STEP_W      = MUL_P_W - ALPHA_SHIFT;
    localparam int SUM_W       = TGT_W + 5;
    localparam int DIFF_W      = TGT_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b1;

    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 17'd65536;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd6400;

    localparam logic signed [TGT_W-1:0] TGT_MAX = 24'sh7FFFFF;
    localparam logic signed [TGT_W-1:0] TGT_MIN = -24'sh800000;

    // per wheel: cos(phi), sin(phi), x*sin(phi) - y*cos(phi) in Q.16
    localparam logic signed [COEF_W-1:0] COEF [WHEEL_COUNT][3] = '{
        '{-17'sd63954,  17'sd14314,  17'sd25121},
        '{-17'sd387,   -17'sd65535, -17'sd4900},
        '{ 17'sd57507,  17'sd31431, -17'sd9413},
        '{-17'sd35784, -17'sd54904, -17'sd12253}
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef enum logic [3:0] {
        STP_MUL_F,
        STP_MUL_S,
        STP_MUL_W,
        STP_ACC_W,
        STP_MUL_VL,
        STP_MUL_VH,
        STP_ACC_SCL,
        STP_RND_NEW,
        STP_SUB_DIF,
        STP_MUL_ALPHA,
        STP_RND_STEP,
        STP_UPD_TGT
    } t_step;

    typedef struct packed {
        logic               active;
        t_step              step;
        logic [WHEEL_W-1:0] wheel;
        logic               load_out;
    } t_seq;

    function automatic logic signed [TGT_W-1:0] sat24(input logic signed [SUM_W-1:0] x);
        logic signed [TGT_W-1:0] r;
        if (x > SUM_W'(TGT_MAX)) begin
            r = TGT_MAX;
        end else if (x < SUM_W'(TGT_MIN)) begin
            r = TGT_MIN;
        end else begin
            r = x[TGT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mecanum_wheel_setpoint_filter_top.sv =====
// top level of the mecanum wheel setpoint filter: datapath, config and stream ports
//
//  channel | direction | handshake                   | payload
//  s       | in        | i_s_tvalid / o_s_tready     | i_s_tdata: forward, sideways, turn
//  m       | out       | o_m_tvalid / i_m_tready     | o_m_tdata: wheel0..wheel3 targets
//  cfg     | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// one command runs the steps of each wheel in turn on the single 26x18 multiplier,
// then the drain step loads the output register and the idle state takes the next
// beat; no new command is accepted until the sequencer is back in idle
// a new command is accepted while the previous result still waits on the m side;
// a stalled m side holds the block in its drain step after the next command is done
// reset is synchronous, active low: targets cleared, weight 65536, radius 6400
`default_nettype none

module mecanum_wheel_setpoint_filter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // forward_speed, sideways_speed, turn_rate
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [95:0]      o_m_tdata,   // wheel0_target .. wheel3_target
    // config write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [mwsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mwsf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // config registers
    logic [mwsf_pkg::ALPHA_W-1:0]  r_alpha;
    logic [mwsf_pkg::RADIUS_W-1:0] r_radius;

    // latched command
    logic signed [mwsf_pkg::IN_W-1:0] r_fwd, r_side, r_turn;

    // working registers
    logic signed [mwsf_pkg::ACC_W-1:0]  r_acc;
    logic signed [mwsf_pkg::TGT_W-1:0]  r_fresh;
    logic signed [mwsf_pkg::DIFF_W-1:0] r_diff;
    logic signed [mwsf_pkg::STEP_W-1:0] r_stp;
    logic signed [mwsf_pkg::TGT_W-1:0]  r_tgt [mwsf_pkg::WHEEL_COUNT];

    // output register
    logic        r_out_valid;
    logic [95:0] r_out_data;

    logic signed [mwsf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [mwsf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [mwsf_pkg::MUL_P_W-1:0] mul_p;
    logic signed [mwsf_pkg::ACC_W-1:0]   acc_rnd;
    logic signed [mwsf_pkg::MUL_P_W-1:0] prod_rnd;
    logic signed [mwsf_pkg::TGT_W-1:0]   tgt_cur;

    mwsf_pkg::t_seq seq;
    logic           ctrl_idle;
    logic           s_accept;
    logic           out_free;

    assign s_accept   = i_s_tvalid & o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = ctrl_idle;
    assign o_cfg_ready = 1'b1;

    mwsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_accept),
        .i_out_free (out_free),
        .o_idle     (ctrl_idle),
        .o_seq      (seq)
    );

    mwsf_mult u_mult (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign tgt_cur = r_tgt[seq.wheel];

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (seq.step)
            mwsf_pkg::STP_MUL_F: begin
                mul_a = mwsf_pkg::MUL_A_W'(r_fwd);
                mul_b = mwsf_pkg::MUL_B_W'(mwsf_pkg::COEF[seq.wheel][0]);
            end
            mwsf_pkg::STP_MUL_S: begin
                mul_a = mwsf_pkg::MUL_A_W'(r_side);
                mul_b = mwsf_pkg::MUL_B_W'(mwsf_pkg::COEF[seq.wheel][1]);
            end
            mwsf_pkg::STP_MUL_W: begin
                mul_a = mwsf_pkg::MUL_A_W'(r_turn);
                mul_b = mwsf_pkg::MUL_B_W'(mwsf_pkg::COEF[seq.wheel][2]);
            end
            // wheel speed times radius, low 17 bits unsigned then high part signed
            mwsf_pkg::STP_MUL_VL: begin
                mul_a = {{(mwsf_pkg::MUL_A_W - mwsf_pkg::VL_W){1'b0}},
                         r_acc[mwsf_pkg::VL_W-1:0]};
                mul_b = {{(mwsf_pkg::MUL_B_W - mwsf_pkg::RADIUS_W){1'b0}}, r_radius};
            end
            mwsf_pkg::STP_MUL_VH: begin
                mul_a = r_acc[mwsf_pkg::VL_W + mwsf_pkg::MUL_A_W - 1:mwsf_pkg::VL_W];
                mul_b = {{(mwsf_pkg::MUL_B_W - mwsf_pkg::RADIUS_W){1'b0}}, r_radius};
            end
            mwsf_pkg::STP_MUL_ALPHA: begin
                mul_a = mwsf_pkg::MUL_A_W'(r_diff);
                mul_b = {{(mwsf_pkg::MUL_B_W - mwsf_pkg::ALPHA_W){1'b0}}, r_alpha};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // round half up at the output scale, and at the weight scale
    assign acc_rnd  = r_acc + (mwsf_pkg::ACC_W'(1) <<< (mwsf_pkg::NEW_SHIFT - 1));
    assign prod_rnd = mul_p + (mwsf_pkg::MUL_P_W'(1) <<< (mwsf_pkg::ALPHA_SHIFT - 1));

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= mwsf_pkg::ALPHA_RST;
            r_radius <= mwsf_pkg::RADIUS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mwsf_pkg::CFG_ALPHA:  r_alpha  <= i_cfg_data;
                mwsf_pkg::CFG_RADIUS: r_radius <= i_cfg_data[mwsf_pkg::RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    // command latch
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_fwd  <= i_s_tdata[15:0];
            r_side <= i_s_tdata[31:16];
            r_turn <= i_s_tdata[47:32];
        end
    end

    // accumulator and per-wheel arithmetic; each step that reads the product takes that of the one before
    always_ff @(posedge i_clk) begin
        if (seq.active) begin
            unique case (seq.step)
                mwsf_pkg::STP_MUL_S:   r_acc <= mwsf_pkg::ACC_W'(mul_p);
                mwsf_pkg::STP_MUL_W:   r_acc <= r_acc + mwsf_pkg::ACC_W'(mul_p);
                mwsf_pkg::STP_ACC_W:   r_acc <= r_acc + mwsf_pkg::ACC_W'(mul_p);
                mwsf_pkg::STP_MUL_VH:  r_acc <= mwsf_pkg::ACC_W'(mul_p);
                mwsf_pkg::STP_ACC_SCL: begin
                    r_acc <= r_acc + (mwsf_pkg::ACC_W'(mul_p) <<< mwsf_pkg::VL_W);
                end
                mwsf_pkg::STP_RND_NEW: begin
                    r_fresh <= mwsf_pkg::sat24(mwsf_pkg::SUM_W'(
                        $signed(acc_rnd[mwsf_pkg::ACC_W-1:mwsf_pkg::NEW_SHIFT])));
                end
                mwsf_pkg::STP_SUB_DIF: begin
                    r_diff <= mwsf_pkg::DIFF_W'(r_fresh) - mwsf_pkg::DIFF_W'(tgt_cur);
                end
                mwsf_pkg::STP_RND_STEP: begin
                    r_stp <= $signed(prod_rnd[mwsf_pkg::MUL_P_W-1:mwsf_pkg::ALPHA_SHIFT]);
                end
                default: ;
            endcase
        end
    end

    // smoothed targets, the block's state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mwsf_pkg::WHEEL_COUNT; i++) begin
                r_tgt[i] <= '0;
            end
        end else if (seq.active && seq.step == mwsf_pkg::STP_UPD_TGT) begin
            r_tgt[seq.wheel] <= mwsf_pkg::sat24(mwsf_pkg::SUM_W'(tgt_cur)
                                                + mwsf_pkg::SUM_W'(r_stp));
        end
    end

    // output register, frees the sequencer from the m side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq.load_out) begin
            r_out_data <= {r_tgt[3], r_tgt[2], r_tgt[1], r_tgt[0]};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq.active |-> !o_s_tready)
        else $error("command ready while sequencer runs");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq.load_out |-> (!r_out_valid || i_m_tready))
        else $error("output register overwritten while held");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (seq.active && seq.step == mwsf_pkg::STP_MUL_F && seq.wheel == '0))
        else $error("accepted command did not start the sequence");

    a_load_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seq.active && seq.step == mwsf_pkg::STP_UPD_TGT
            && seq.wheel == mwsf_pkg::WHEEL_W'(mwsf_pkg::WHEEL_COUNT - 1))
        |=> (!seq.active && !o_s_tready))
        else $error("sequencer left the last wheel without draining");
`endif

endmodule

`default_nettype wire

// ===== hdl/mwsf_mult.sv =====
// shared signed multiplier with registered product
`default_nettype none

module mwsf_mult (
    input  wire logic                                i_clk,
    input  wire logic signed [mwsf_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [mwsf_pkg::MUL_B_W-1:0] i_b,
    output logic signed      [mwsf_pkg::MUL_P_W-1:0] o_p
);

    logic signed [mwsf_pkg::MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== hdl/mwsf_ctrl.sv =====
// sequencer: walks the steps of each wheel and hands the result to the output
`default_nettype none

module mwsf_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_out_free,
    output logic                o_idle,
    output mwsf_pkg::t_seq      o_seq
);

    mwsf_pkg::t_state                 r_state, n_state;
    mwsf_pkg::t_step                  r_step,  n_step;
    logic [mwsf_pkg::WHEEL_W-1:0]     r_wheel, n_wheel;
    logic                             load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mwsf_pkg::ST_IDLE;
            r_step  <= mwsf_pkg::STP_MUL_F;
            r_wheel <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_wheel <= n_wheel;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_wheel  = r_wheel;
        load_out = 1'b0;
        unique case (r_state)
            mwsf_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = mwsf_pkg::ST_RUN;
                    n_step  = mwsf_pkg::STP_MUL_F;
                    n_wheel = '0;
                end
            end
            mwsf_pkg::ST_RUN: begin
                if (r_step == mwsf_pkg::STP_UPD_TGT) begin
                    n_step = mwsf_pkg::STP_MUL_F;
                    if (r_wheel == mwsf_pkg::WHEEL_W'(mwsf_pkg::WHEEL_COUNT - 1)) begin
                        n_wheel = '0;
                        n_state = mwsf_pkg::ST_DRAIN;
                    end else begin
                        n_wheel = r_wheel + 1'b1;
                    end
                end else begin
                    n_step = mwsf_pkg::t_step'(r_step + 1'b1);
                end
            end
            mwsf_pkg::ST_DRAIN: begin
                // wait until the output register can take the new beat
                if (i_out_free) begin
                    load_out = 1'b1;
                    n_state  = mwsf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mwsf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_idle         = (r_state == mwsf_pkg::ST_IDLE);
    assign o_seq.active   = (r_state == mwsf_pkg::ST_RUN);
    assign o_seq.step     = r_step;
    assign o_seq.wheel    = r_wheel;
    assign o_seq.load_out = load_out;

endmodule

`default_nettype wire
